// ----- hw/rtl/mbrc_pkg.sv -----
`timescale 1ns / 1ps

package mbrc_pkg;

    // Field widths of the channels.
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned FUNC_W      = 7;
    localparam int unsigned STATUS_W    = 3;
    localparam int unsigned FRAME_LEN_W = 9;
    localparam int unsigned CRC_W       = 16;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam int unsigned RESULT_W    = STATUS_W + BYTE_W + FRAME_LEN_W;
    localparam int unsigned M_TDATA_W   = ((RESULT_W + 7) / 8) * 8;

    // Default frame limit in bytes.
    localparam int unsigned MAX_FRAME_DEF = 256;

    // CRC-16/MODBUS constants.
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

    // Bit that marks an exception response in the function byte.
    localparam logic [BYTE_W-1:0] FN_EXCEPTION_BIT = 8'h80;
    // Shortest frame worth checking.
    localparam logic [FRAME_LEN_W-1:0] MIN_FRAME = 9'h002;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLAVE_ADDR = 2'd0,
        CFG_FUNCTION   = 2'd1,
        CFG_LENGTH     = 2'd2
    } cfg_idx_t;

    // Meaning of the tuser bit on the input side.
    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_EOF  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 3'd0,
        ST_OVERFLOW      = 3'd1,
        ST_TOO_SHORT     = 3'd2,
        ST_CRC_BAD       = 3'd3,
        ST_ADDR_MISMATCH = 3'd4,
        ST_LEN_MISMATCH  = 3'd5,
        ST_EXCEPTION     = 3'd6,
        ST_UNKNOWN_FN    = 3'd7
    } status_t;

    // Running state of the frame under reception.
    typedef struct packed {
        logic [CRC_W-1:0]       crc;
        logic [FRAME_LEN_W-1:0] count;
        logic [BYTE_W-1:0]      addr_byte;
        logic [BYTE_W-1:0]      func_byte;
        logic [BYTE_W-1:0]      third_byte;
        logic                   overflowed;
    } frame_state_t;

    // Expected values taken from the configuration registers.
    typedef struct packed {
        logic [BYTE_W-1:0] slave_addr;
        logic [FUNC_W-1:0] function_code;
        logic [BYTE_W-1:0] length;
    } cfg_t;

    typedef struct packed {
        logic [FRAME_LEN_W-1:0] frame_length;
        logic [BYTE_W-1:0]      exception_code;
        status_t                status;
    } result_t;

    // One byte through the reflected CRC-16, LSB first.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/mbrc_frame_state.sv -----
`timescale 1ns / 1ps

// Holds the CRC, byte count, header bytes and overflow flag of the frame
// being received, and clears them when the frame is closed.
module mbrc_frame_state #(
    parameter int unsigned MAX_FRAME = mbrc_pkg::MAX_FRAME_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        byte_en,
    input  logic                        eof_en,
    input  logic [mbrc_pkg::BYTE_W-1:0] rx_byte,
    output mbrc_pkg::frame_state_t      state
);

    localparam int unsigned COUNT_W = $clog2(MAX_FRAME + 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_FRAME);

    logic [mbrc_pkg::CRC_W-1:0]  crc_reg,   crc_next;
    logic [COUNT_W-1:0]          count_reg, count_next;
    logic [mbrc_pkg::BYTE_W-1:0] addr_reg,  addr_next;
    logic [mbrc_pkg::BYTE_W-1:0] func_reg,  func_next;
    logic [mbrc_pkg::BYTE_W-1:0] third_reg, third_next;
    logic                        ovf_reg,   ovf_next;

    always_comb begin
        crc_next   = crc_reg;
        count_next = count_reg;
        addr_next  = addr_reg;
        func_next  = func_reg;
        third_next = third_reg;
        ovf_next   = ovf_reg;
        if (eof_en) begin
            crc_next   = mbrc_pkg::CRC_INIT;
            count_next = '0;
            addr_next  = '0;
            func_next  = '0;
            third_next = '0;
            ovf_next   = 1'b0;
        end else if (byte_en) begin
            if (count_reg >= COUNT_MAX) begin
                // Bytes past the limit only raise the flag.
                ovf_next = 1'b1;
            end else begin
                if (count_reg == COUNT_W'(0)) begin
                    addr_next = rx_byte;
                end
                if (count_reg == COUNT_W'(1)) begin
                    func_next = rx_byte;
                end
                if (count_reg == COUNT_W'(2)) begin
                    third_next = rx_byte;
                end
                crc_next   = mbrc_pkg::crc_byte(crc_reg, rx_byte);
                count_next = count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= mbrc_pkg::CRC_INIT;
            count_reg <= '0;
            addr_reg  <= '0;
            func_reg  <= '0;
            third_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
            addr_reg  <= addr_next;
            func_reg  <= func_next;
            third_reg <= third_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_comb begin
        state.crc        = crc_reg;
        state.count      = mbrc_pkg::FRAME_LEN_W'(count_reg);
        state.addr_byte  = addr_reg;
        state.func_byte  = func_reg;
        state.third_byte = third_reg;
        state.overflowed = ovf_reg;
    end

endmodule

// ----- hw/rtl/mbrc_verdict.sv -----
`timescale 1ns / 1ps

// Priority chain that turns the frame state into one verdict.
module mbrc_verdict (
    input  mbrc_pkg::frame_state_t state,
    input  mbrc_pkg::cfg_t         cfg,
    output mbrc_pkg::result_t      result
);

    logic [mbrc_pkg::BYTE_W-1:0] fn_normal;
    logic [mbrc_pkg::BYTE_W-1:0] fn_exception;

    assign fn_normal    = {1'b0, cfg.function_code};
    assign fn_exception = fn_normal | mbrc_pkg::FN_EXCEPTION_BIT;

    always_comb begin
        result.frame_length   = state.count;
        result.exception_code = '0;
        if (state.overflowed) begin
            result.status = mbrc_pkg::ST_OVERFLOW;
        end else if (state.count < mbrc_pkg::MIN_FRAME) begin
            result.status = mbrc_pkg::ST_TOO_SHORT;
        end else if (state.crc != '0) begin
            result.status = mbrc_pkg::ST_CRC_BAD;
        end else if (state.addr_byte != cfg.slave_addr) begin
            result.status = mbrc_pkg::ST_ADDR_MISMATCH;
        end else if (state.func_byte == fn_normal) begin
            if (state.count == {1'b0, cfg.length}) begin
                result.status = mbrc_pkg::ST_OK;
            end else begin
                result.status = mbrc_pkg::ST_LEN_MISMATCH;
            end
        end else if (state.func_byte == fn_exception) begin
            result.status         = mbrc_pkg::ST_EXCEPTION;
            result.exception_code = state.third_byte;
        end else begin
            result.status = mbrc_pkg::ST_UNKNOWN_FN;
        end
    end

endmodule

// ----- hw/rtl/modbus_rtu_response_checker.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Ports                      Payload
// -------   ---------  -------------------------  ------------------------------------
// s_        in         s_tvalid/s_tready          tdata: rx_byte; tuser: req_type
// m_        out        m_tvalid/m_tready          tdata: status, exception_code,
//                                                 frame_length (low bit up), zero pad
// cfg_      in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// Each beat is registered on input: a data beat updates the CRC, count and header
// bytes in the next cycle, and an end-of-frame beat, once it may advance, loads
// its verdict into the output register from the frame state. A beat can be
// taken on every edge; an end-of-frame beat waits only while an untaken verdict
// fills the output register, and data beats never wait. aresetn is synchronous and
// active low: it restores the register defaults, empties both sides, holds readies low.
module modbus_rtu_response_checker #(
    parameter int unsigned MAX_FRAME = mbrc_pkg::MAX_FRAME_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mbrc_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] rx_byte
    input  logic                             s_tuser,   // [0] req_type

    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mbrc_pkg::M_TDATA_W-1:0]   m_tdata,   // [2:0] status,
                                                        // [10:3] exception_code,
                                                        // [19:11] frame_length,
                                                        // [23:20] zero

    // Configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mbrc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mbrc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Input register.
    logic                        in_valid_reg;
    logic                        in_type_reg;
    logic [mbrc_pkg::BYTE_W-1:0] in_byte_reg;

    // Output register.
    logic              out_valid_reg;
    mbrc_pkg::result_t result_reg;

    // Configuration registers.
    mbrc_pkg::cfg_t cfg_reg;

    mbrc_pkg::frame_state_t frame_state;
    mbrc_pkg::result_t      verdict;

    logic in_is_eof;
    logic advance;
    logic byte_en;
    logic eof_en;

    // The held beat moves on unless it is an end of frame and the output
    // register is still occupied by a verdict nobody has taken.
    assign in_is_eof = (in_type_reg == mbrc_pkg::REQ_EOF);
    assign advance   = in_valid_reg && !(in_is_eof && out_valid_reg && !m_tready);
    assign byte_en   = advance && !in_is_eof;
    assign eof_en    = advance && in_is_eof;

    // Nothing is taken while reset is applied.
    assign s_tready  = aresetn && (!in_valid_reg || advance);
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_type_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    mbrc_frame_state #(
        .MAX_FRAME (MAX_FRAME)
    ) u_frame_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .byte_en (byte_en),
        .eof_en  (eof_en),
        .rx_byte (in_byte_reg),
        .state   (frame_state)
    );

    mbrc_verdict u_verdict (
        .state  (frame_state),
        .cfg    (cfg_reg),
        .result (verdict)
    );

    // Output register: loaded by an end-of-frame beat, emptied when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (eof_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (eof_en) begin
            result_reg <= verdict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = mbrc_pkg::M_TDATA_W'(result_reg);

    // Configuration writes; an index beyond the register list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slave_addr    <= 8'd1;
            cfg_reg.function_code <= 7'd3;
            cfg_reg.length        <= 8'd0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mbrc_pkg::CFG_SLAVE_ADDR: cfg_reg.slave_addr    <= cfg_data;
                mbrc_pkg::CFG_FUNCTION:   cfg_reg.function_code <= cfg_data[mbrc_pkg::FUNC_W-1:0];
                mbrc_pkg::CFG_LENGTH:     cfg_reg.length        <= cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule
